/* hdl/hsc_pkg.sv */
// ----------------------------------------------------------------------------
// hsc_pkg: shared types and constants of the start code splitter
// Field widths, the buffer size limit and the event record that the scan
// front passes to the result back end through the event queue.
// ----------------------------------------------------------------------------
`default_nettype none

package hsc_pkg;

   localparam int POS_WIDTH = 25;
   localparam int BYTE_WIDTH = 8;

   localparam logic [POS_WIDTH-1:0] MAX_BUFFER_BYTES = 25'd16777216;
   localparam logic [POS_WIDTH-1:0] CODE3_LEN = 25'd3;
   localparam logic [POS_WIDTH-1:0] CODE4_LEN = 25'd4;
   localparam logic [POS_WIDTH-1:0] POS_ONE = 25'd1;

   localparam logic [1:0] SKIP_AFTER_CODE = 2'd3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;
   localparam logic [QUEUE_CNT_W-1:0] QUEUE_FULL_COUNT = 3'd4;

   localparam int RSP_DATA_WIDTH = 56;

   // Results caused by one input byte: a unit closed by a new start code,
   // and/or the final result at the buffer end.
   typedef struct packed {
      logic                 has_mid;
      logic [POS_WIDTH-1:0] mid_offset;
      logic [POS_WIDTH-1:0] mid_length;
      logic                 has_end;
      logic [POS_WIDTH-1:0] end_offset;
      logic [POS_WIDTH-1:0] end_length;
      logic                 end_none;
   } event_type;

   typedef struct packed {
      logic full;
      logic valid;
   } queue_status_type;

endpackage

`default_nettype wire

/* hdl/hsc_front.sv */
// ----------------------------------------------------------------------------
// hsc_front: byte scanner
// Keeps the last four bytes and the unit bookkeeping, detects start codes
// and builds one event record for every byte that causes a result.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic [hsc_pkg::BYTE_WIDTH-1:0] data_byte,
   input  wire logic                          end_of_buffer,
   output logic                               push,
   output hsc_pkg::event_type                 push_event
);

   logic [hsc_pkg::BYTE_WIDTH-1:0] win0_ff, win1_ff, win2_ff, win3_ff;
   logic [hsc_pkg::POS_WIDTH-1:0]  pos_ff, pos_in;
   logic [1:0]                     skip_ff, skip_in;
   logic [hsc_pkg::POS_WIDTH-1:0]  start_ff, start_in;
   logic                           open_ff, open_in;

   logic                           four, three, code_found;
   logic [hsc_pkg::POS_WIDTH-1:0]  code_len, code_pos, pos_next;
   logic [hsc_pkg::POS_WIDTH-1:0]  scan_start;
   logic                           scan_open;

   always_comb begin
      four = (skip_ff == 2'd0) && (pos_ff >= hsc_pkg::CODE4_LEN) &&
             (win3_ff == 8'h00) && (win2_ff == 8'h00) &&
             (win1_ff == 8'h00) && (win0_ff == 8'h01);
      three = (skip_ff <= 2'd1) && (pos_ff >= hsc_pkg::CODE3_LEN) &&
              (win2_ff == 8'h00) && (win1_ff == 8'h00) && (win0_ff == 8'h01);
      code_found = four || three;
      code_len = four ? hsc_pkg::CODE4_LEN : hsc_pkg::CODE3_LEN;
      code_pos = pos_ff - code_len;
      pos_next = (pos_ff >= hsc_pkg::MAX_BUFFER_BYTES) ? hsc_pkg::MAX_BUFFER_BYTES
                                                       : pos_ff + hsc_pkg::POS_ONE;

      scan_start = code_found ? pos_ff : start_ff;
      scan_open = code_found || open_ff;

      push_event.has_mid = code_found && open_ff;
      push_event.mid_offset = start_ff;
      push_event.mid_length = (code_pos > start_ff) ? code_pos - start_ff : '0;
      push_event.has_end = end_of_buffer;
      push_event.end_offset = scan_open ? scan_start : '0;
      push_event.end_length = (scan_open && (pos_next > scan_start)) ?
                              pos_next - scan_start : '0;
      push_event.end_none = !scan_open;

      push = accept && (push_event.has_mid || push_event.has_end);

      if (code_found) begin
         skip_in = hsc_pkg::SKIP_AFTER_CODE;
      end else if (skip_ff != 2'd0) begin
         skip_in = skip_ff - 2'd1;
      end else begin
         skip_in = skip_ff;
      end
      pos_in = pos_next;
      start_in = scan_start;
      open_in = scan_open;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win0_ff <= '0;
         win1_ff <= '0;
         win2_ff <= '0;
         win3_ff <= '0;
         pos_ff <= '0;
         skip_ff <= '0;
         start_ff <= '0;
         open_ff <= 1'b0;
      end else if (accept) begin
         if (end_of_buffer) begin
            // The buffer is finished: everything returns to its idle state.
            win0_ff <= '0;
            win1_ff <= '0;
            win2_ff <= '0;
            win3_ff <= '0;
            pos_ff <= '0;
            skip_ff <= '0;
            start_ff <= '0;
            open_ff <= 1'b0;
         end else begin
            win0_ff <= data_byte;
            win1_ff <= win0_ff;
            win2_ff <= win1_ff;
            win3_ff <= win2_ff;
            pos_ff <= pos_in;
            skip_ff <= skip_in;
            start_ff <= start_in;
            open_ff <= open_in;
         end
      end
   end

endmodule

`default_nettype wire

/* hdl/hsc_queue.sv */
// ----------------------------------------------------------------------------
// hsc_queue: event queue
// Short FIFO of event records between the scanner and the result back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire hsc_pkg::event_type   push_event,
   input  wire logic                 pop,
   output hsc_pkg::event_type        head_event,
   output hsc_pkg::queue_status_type status
);

   hsc_pkg::event_type                entries_ff [hsc_pkg::QUEUE_DEPTH];
   logic [hsc_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [hsc_pkg::QUEUE_CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      status.full = (count_ff == hsc_pkg::QUEUE_FULL_COUNT);
      status.valid = (count_ff != '0);
      head_event = entries_ff[rd_ptr_ff];
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_event;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/hsc_back.sv */
// ----------------------------------------------------------------------------
// hsc_back: result sequencer
// Unpacks each event record into one or two result transfers and holds
// the current result in an output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire hsc_pkg::event_type           head_event,
   input  wire hsc_pkg::queue_status_type    status,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [hsc_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic [0:0]                        rsp_tuser,
   output logic                              rsp_tlast
);

   logic                          valid_ff, valid_in;
   logic                          mid_done_ff, mid_done_in;
   logic [hsc_pkg::POS_WIDTH-1:0] offset_ff, offset_in;
   logic [hsc_pkg::POS_WIDTH-1:0] length_ff, length_in;
   logic                          none_ff, none_in;
   logic                          last_ff, last_in;
   logic                          load, take, emit_mid;

   always_comb begin
      load = !valid_ff || rsp_tready;
      take = load && status.valid;
      emit_mid = head_event.has_mid && !mid_done_ff;

      // A record with both results stays at the head until its second one.
      pop = take && !(emit_mid && head_event.has_end);
      mid_done_in = take ? (emit_mid && head_event.has_end) : mid_done_ff;

      valid_in = take ? 1'b1 : (load ? 1'b0 : valid_ff);
      offset_in = emit_mid ? head_event.mid_offset : head_event.end_offset;
      length_in = emit_mid ? head_event.mid_length : head_event.end_length;
      none_in = emit_mid ? 1'b0 : head_event.end_none;
      last_in = !emit_mid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         mid_done_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         mid_done_ff <= mid_done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         offset_ff <= offset_in;
         length_ff <= length_in;
         none_ff <= none_in;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = {6'b0, length_ff, offset_ff};
   assign rsp_tuser = none_ff;
   assign rsp_tlast = last_ff;

endmodule

`default_nettype wire

/* hdl/h264_start_code_splitter_unit.sv */
// ----------------------------------------------------------------------------
// h264_start_code_splitter_unit: Annex B start code splitter
// Latency: a result passes through the event queue and the output register.
// Throughput: one byte per cycle while the event queue is not full; a byte that
// causes two results needs two output transfers, absorbed by the four-entry event queue.
// Reset: synchronous, active high; clears the scan state, queue and output.
// ----------------------------------------------------------------------------
`default_nettype none

module h264_start_code_splitter_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,   // end_of_buffer
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // [24:0] unit_offset, [49:25] unit_length
   output logic [0:0]       rsp_tuser,   // [0] no_units
   output logic             rsp_tlast    // last_unit
);

   logic                      accept, push, pop;
   hsc_pkg::event_type        push_event, head_event;
   hsc_pkg::queue_status_type status;

   assign req_tready = !status.full;
   assign accept = req_tvalid && req_tready;

   hsc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_tdata),
      .end_of_buffer (req_tlast),
      .push          (push),
      .push_event    (push_event)
   );

   hsc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_event (push_event),
      .pop        (pop),
      .head_event (head_event),
      .status     (status)
   );

   hsc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_event (head_event),
      .status     (status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

/* sim/h264_start_code_splitter_unit_tb.sv */
// ----------------------------------------------------------------------------
// h264_start_code_splitter_unit_tb: self-checking bench of the splitter
// Feeds buffers byte by byte over the request stream, with random gaps on
// both sides. A scoreboard predicts the NAL unit results of each byte, and
// every result transfer is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
`default_nettype none

module h264_start_code_splitter_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [hsc_pkg::POS_WIDTH-1:0] offset;
      logic [hsc_pkg::POS_WIDTH-1:0] length;
      logic                          none;
      logic                          last;
   } nal_unit_type;

   class nal_unit_scoreboard;
      nal_unit_type                  expected_units[$];
      int                            errors;
      logic [7:0]                    window[4];
      logic [hsc_pkg::POS_WIDTH-1:0] position;
      logic [hsc_pkg::POS_WIDTH-1:0] unit_start;
      logic [1:0]                    skip;
      bit                            unit_open;

      function new();
         errors = 0;
         clear_state();
      endfunction

      function void clear_state();
         foreach (window[i]) window[i] = 8'h00;
         position = '0;
         unit_start = '0;
         skip = '0;
         unit_open = 0;
      endfunction

      function logic [hsc_pkg::POS_WIDTH-1:0] sat_next(logic [hsc_pkg::POS_WIDTH-1:0] v);
         return (v >= hsc_pkg::MAX_BUFFER_BYTES) ? hsc_pkg::MAX_BUFFER_BYTES
                                                 : v + hsc_pkg::POS_ONE;
      endfunction

      // Works out the results that one accepted request byte causes.
      function void note_input(logic [7:0] data_byte, bit end_of_buffer);
         bit                            four;
         bit                            three;
         logic [hsc_pkg::POS_WIDTH-1:0] code_len;
         logic [hsc_pkg::POS_WIDTH-1:0] code_pos;
         logic [hsc_pkg::POS_WIDTH-1:0] size;
         nal_unit_type                  unit;
         four = window[3] == 8'h00 && window[2] == 8'h00 &&
                window[1] == 8'h00 && window[0] == 8'h01;
         three = window[2] == 8'h00 && window[1] == 8'h00 && window[0] == 8'h01;
         code_len = '0;
         // The four-byte code starts one position earlier, so it wins.
         if (skip == 2'd0 && position >= hsc_pkg::CODE4_LEN && four)
            code_len = hsc_pkg::CODE4_LEN;
         else if (skip <= 2'd1 && position >= hsc_pkg::CODE3_LEN && three)
            code_len = hsc_pkg::CODE3_LEN;
         if (code_len != '0) begin
            code_pos = position - code_len;
            if (unit_open) begin
               unit.offset = unit_start;
               unit.length = (code_pos > unit_start) ? code_pos - unit_start : '0;
               unit.none = 1'b0;
               unit.last = 1'b0;
               expected_units.push_back(unit);
            end
            unit_start = position;
            unit_open = 1;
            skip = hsc_pkg::SKIP_AFTER_CODE;
         end else if (skip != 2'd0) begin
            skip = skip - 2'd1;
         end
         window[3] = window[2];
         window[2] = window[1];
         window[1] = window[0];
         window[0] = data_byte;
         if (end_of_buffer) begin
            size = sat_next(position);
            if (unit_open) begin
               unit.offset = unit_start;
               unit.length = (size > unit_start) ? size - unit_start : '0;
               unit.none = 1'b0;
            end else begin
               unit.offset = '0;
               unit.length = '0;
               unit.none = 1'b1;
            end
            unit.last = 1'b1;
            expected_units.push_back(unit);
            clear_state();
         end else begin
            position = sat_next(position);
         end
      endfunction

      function void check_result(logic [hsc_pkg::POS_WIDTH-1:0] offset,
                                 logic [hsc_pkg::POS_WIDTH-1:0] length,
                                 logic none, logic last);
         nal_unit_type unit;
         if (expected_units.size() == 0) begin
            $error("unexpected result: offset %0d, length %0d", offset, length);
            errors++;
            return;
         end
         unit = expected_units.pop_front();
         if (offset !== unit.offset) begin
            $error("unit_offset: expected %0d, actual %0d", unit.offset, offset);
            errors++;
         end
         if (length !== unit.length) begin
            $error("unit_length: expected %0d, actual %0d", unit.length, length);
            errors++;
         end
         if (none !== unit.none) begin
            $error("no_units: expected %0d, actual %0d", unit.none, none);
            errors++;
         end
         if (last !== unit.last) begin
            $error("last_unit: expected %0d, actual %0d", unit.last, last);
            errors++;
         end
      endfunction

      function int pending();
         return expected_units.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        rsp_tlast;

   nal_unit_scoreboard unit_board = new();
   logic [7:0]         byte_seq[$];
   bit                 quiet_phase = 0;
   int                 sent_items = 0;

   h264_start_code_splitter_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Zeros and ones are drawn often so that start codes appear by chance.
   function logic [7:0] code_rich_byte();
      case ($urandom_range(0, 3))
         0: return 8'h00;
         1: return 8'h01;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] data_byte, input bit end_of_buffer);
      int idle;
      idle = quiet_phase ? 0 : $urandom_range(0, 12);
      @(negedge clock);
      if (idle > 0) begin
         req_tvalid <= 1'b0;
         repeat (idle) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data_byte;
      req_tlast <= end_of_buffer;
      do @(posedge clock); while (!req_tready);
      unit_board.note_input(data_byte, end_of_buffer);
      sent_items++;
   endtask

   task automatic send_stream();
      foreach (byte_seq[i]) send_byte(byte_seq[i], i == byte_seq.size() - 1);
   endtask

   task automatic build_random_buffer();
      int kind;
      int units;
      int cut;
      byte_seq.delete();
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
         repeat ($urandom_range(0, 3)) byte_seq.push_back(code_rich_byte());
         units = $urandom_range(1, 4);
         repeat (units) begin
            if ($urandom_range(0, 1)) byte_seq.push_back(8'h00);
            byte_seq.push_back(8'h00);
            byte_seq.push_back(8'h00);
            byte_seq.push_back(8'h01);
            repeat ($urandom_range(0, 8))
               byte_seq.push_back(($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom));
         end
         // A broken buffer is cut off at a random point before its end.
         if (kind == 7 && byte_seq.size() > 1) begin
            cut = $urandom_range(1, byte_seq.size() - 1);
            while (byte_seq.size() > cut) void'(byte_seq.pop_back());
         end
      end else begin
         repeat ($urandom_range(1, 12)) byte_seq.push_back(code_rich_byte());
      end
   endtask

   initial begin
      int guard;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'h00;
      req_tlast = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed buffers: too short to match, a lone code just fitting,
      // both code lengths, back-to-back codes and a code with nothing after it.
      byte_seq = '{8'h00};
      send_stream();
      byte_seq = '{8'h00, 8'h00, 8'h01};
      send_stream();
      byte_seq = '{8'h00, 8'h00, 8'h01, 8'hFF};
      send_stream();
      byte_seq = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h80};
      send_stream();
      byte_seq = '{8'hFF, 8'h00, 8'h00, 8'h01, 8'h7F, 8'h00, 8'h00, 8'h01,
                   8'h00, 8'h00, 8'h01};
      send_stream();

      while (sent_items < 1000) begin
         quiet_phase = ($urandom_range(0, 3) == 0);
         build_random_buffer();
         send_stream();
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      guard = 0;
      while (unit_board.pending() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (10) @(posedge clock);
      if (unit_board.pending() != 0) begin
         $error("%0d expected results never arrived", unit_board.pending());
         unit_board.errors++;
      end
      if (unit_board.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Result side: a random stall before every transfer outside quiet phases.
   initial begin
      int idle;
      rsp_tready = 1'b0;
      wait (!reset);
      forever begin
         idle = quiet_phase ? 0 : $urandom_range(0, 12);
         @(negedge clock);
         if (idle > 0) begin
            rsp_tready <= 1'b0;
            repeat (idle) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         unit_board.check_result(rsp_tdata[24:0], rsp_tdata[49:25],
                                 rsp_tuser[0], rsp_tlast);
      end
   end

endmodule

`default_nettype wire
